/* rtl/csvp_pkg.sv */
// Shared types and constants for the CSV servo frame parser.
// No dependencies; imported by every other file of the block.
package csvp_pkg;

  localparam int FIELD_COUNT = 6;
  localparam int MAX_DIGITS  = 4;

  localparam int POS_W  = 12;
  localparam int ACC_W  = 14;
  localparam int TMR_W  = 16;
  localparam int IDX_W  = $clog2(FIELD_COUNT);
  localparam int DIG_W  = $clog2(MAX_DIGITS + 1);
  localparam int CLS_W  = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIELD_COUNT - 1);
  localparam logic [DIG_W-1:0] DIG_MAX  = DIG_W'(MAX_DIGITS);
  localparam logic [TMR_W-1:0] TMR_SAT  = {TMR_W{1'b1}};

  // Token classes
  localparam logic [CLS_W-1:0] CLS_TICK  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_DIGIT = 3'd1;
  localparam logic [CLS_W-1:0] CLS_COMMA = 3'd2;
  localparam logic [CLS_W-1:0] CLS_NL    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_CR    = 3'd4;
  localparam logic [CLS_W-1:0] CLS_OTHER = 3'd5;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DEG_MIN = 3'd0;
  localparam logic [2:0] REG_DEG_MAX = 3'd1;
  localparam logic [2:0] REG_US_MIN  = 3'd2;
  localparam logic [2:0] REG_US_MAX  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  localparam logic [POS_W-1:0] RST_DEG_MIN = 12'd5;
  localparam logic [POS_W-1:0] RST_DEG_MAX = 12'd175;
  localparam logic [POS_W-1:0] RST_US_MIN  = 12'd500;
  localparam logic [POS_W-1:0] RST_US_MAX  = 12'd2400;
  localparam logic [TMR_W-1:0] RST_TIMEOUT = 16'd100;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [3:0]       digit;
  } tok_t;

  typedef struct packed {
    logic [POS_W-1:0] deg_min;
    logic [POS_W-1:0] deg_max;
    logic [POS_W-1:0] us_min;
    logic [POS_W-1:0] us_max;
    logic [TMR_W-1:0] timeout;
  } cfg_t;

endpackage

/* rtl/csvp_if.sv */
// Valid/ready channel interfaces for the parser's input items and result frames.
// Depends on csvp_pkg for field widths.
interface csvp_item_if import csvp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface csvp_frame_if import csvp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic             unit_is_micro;
  logic [POS_W-1:0] pos_0;
  logic [POS_W-1:0] pos_1;
  logic [POS_W-1:0] pos_2;
  logic [POS_W-1:0] pos_3;
  logic [POS_W-1:0] pos_4;
  logic [POS_W-1:0] pos_5;

  modport source (output valid, status, unit_is_micro, pos_0, pos_1, pos_2, pos_3, pos_4,
                  pos_5, input ready);
  modport sink   (input valid, status, unit_is_micro, pos_0, pos_1, pos_2, pos_3, pos_4,
                  pos_5, output ready);
endinterface

/* rtl/csvp_queue.sv */
// Two-entry token queue between the classifier and the parser.
// Depends on csvp_pkg (tok_t).
module csvp_queue import csvp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_data,
  output logic full,
  input  logic pop,
  output tok_t pop_data,
  output logic empty
);

  tok_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/csvp_front.sv */
// Input side: takes items and classifies each into a token for the queue.
// Depends on csvp_pkg and csvp_item_if.
module csvp_front import csvp_pkg::*; (
  csvp_item_if.sink item,
  input  logic      q_full,
  output logic      push,
  output tok_t      tok
);

  assign item.ready = ~q_full;
  assign push       = item.valid & ~q_full;

  always_comb begin
    tok.digit = item.rx_byte[3:0];
    if (item.command == CMD_TICK) begin
      tok.cls = CLS_TICK;
    end else if (item.rx_byte >= CH_0 && item.rx_byte <= CH_9) begin
      tok.cls = CLS_DIGIT;
    end else if (item.rx_byte == CH_COMMA) begin
      tok.cls = CLS_COMMA;
    end else if (item.rx_byte == CH_LF) begin
      tok.cls = CLS_NL;
    end else if (item.rx_byte == CH_CR) begin
      tok.cls = CLS_CR;
    end else begin
      tok.cls = CLS_OTHER;
    end
  end

endmodule

/* rtl/csvp_back.sv */
// Parser core: runs the line state per token, range-checks on newline and
// holds the result frame register. Depends on csvp_pkg and csvp_frame_if.
module csvp_back import csvp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         tok_valid,
  input  tok_t         tok,
  output logic         pop,
  csvp_frame_if.source frame
);

  logic [IDX_W-1:0] field_index, field_index_next;
  logic [ACC_W-1:0] value_acc, value_acc_next;
  logic [DIG_W-1:0] digits_seen, digits_seen_next;
  logic             field_has_digit, field_has_digit_next;
  logic             discarding, discarding_next;
  logic             in_line, in_line_next;
  logic [TMR_W-1:0] line_timer, line_timer_next;
  logic [ACC_W-1:0] stored_fields [FIELD_COUNT-1];

  logic             frame_vld;
  logic             frame_status;
  logic             frame_unit;
  logic [POS_W-1:0] pos [FIELD_COUNT];

  logic             emit, rej, rej_disc, store_en, all_deg, all_us;
  logic [ACC_W+2:0] prod;
  logic [TMR_W-1:0] timer_inc;
  logic [ACC_W-1:0] vals [FIELD_COUNT];

  assign pop = tok_valid & (~frame_vld | frame.ready);

  assign prod      = {value_acc, 3'b000} + {2'b00, value_acc, 1'b0}
                   + {{(ACC_W-1){1'b0}}, tok.digit};
  assign timer_inc = (line_timer == TMR_SAT) ? line_timer : line_timer + 1'b1;

  // Six values checked against both windows in parallel
  always_comb begin
    all_deg = 1'b1;
    all_us  = 1'b1;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (i < FIELD_COUNT - 1) vals[i] = stored_fields[i];
      else                     vals[i] = value_acc;
      if (vals[i] < {2'b00, cfg.deg_min} || vals[i] > {2'b00, cfg.deg_max}) all_deg = 1'b0;
      if (vals[i] < {2'b00, cfg.us_min}  || vals[i] > {2'b00, cfg.us_max})  all_us  = 1'b0;
    end
  end

  always_comb begin
    field_index_next     = field_index;
    value_acc_next       = value_acc;
    digits_seen_next     = digits_seen;
    field_has_digit_next = field_has_digit;
    discarding_next      = discarding;
    in_line_next         = in_line;
    line_timer_next      = line_timer;
    emit                 = 1'b0;
    rej                  = 1'b0;
    rej_disc             = 1'b0;
    store_en             = 1'b0;

    if (pop) begin
      if (tok.cls == CLS_TICK) begin
        if (in_line && !discarding) begin
          if (timer_inc > cfg.timeout) begin
            rej      = 1'b1;
            rej_disc = 1'b1;
          end else begin
            line_timer_next = timer_inc;
          end
        end
      end else if (discarding) begin
        if (tok.cls == CLS_NL) discarding_next = 1'b0;
      end else if (!in_line && (tok.cls == CLS_NL || tok.cls == CLS_CR)) begin
        // idle line ends are dropped
      end else begin
        in_line_next = 1'b1;
        if (!in_line) line_timer_next = '0;
        unique case (tok.cls)
          CLS_CR: begin
          end
          CLS_DIGIT: begin
            if (digits_seen == DIG_MAX) begin
              rej      = 1'b1;
              rej_disc = 1'b1;
            end else begin
              value_acc_next       = prod[ACC_W-1:0];
              digits_seen_next     = digits_seen + 1'b1;
              field_has_digit_next = 1'b1;
            end
          end
          CLS_COMMA: begin
            if (!field_has_digit || field_index >= LAST_IDX) begin
              rej      = 1'b1;
              rej_disc = 1'b1;
            end else begin
              store_en             = 1'b1;
              field_index_next     = field_index + 1'b1;
              value_acc_next       = '0;
              digits_seen_next     = '0;
              field_has_digit_next = 1'b0;
            end
          end
          CLS_NL: begin
            if (!field_has_digit || field_index != LAST_IDX || (!all_deg && !all_us)) begin
              rej = 1'b1;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin
            rej      = 1'b1;
            rej_disc = 1'b1;
          end
        endcase
      end
    end

    if (rej || emit) begin
      field_index_next     = '0;
      value_acc_next       = '0;
      digits_seen_next     = '0;
      field_has_digit_next = 1'b0;
      in_line_next         = 1'b0;
      line_timer_next      = '0;
    end
    if (rej) discarding_next = rej_disc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index     <= '0;
      value_acc       <= '0;
      digits_seen     <= '0;
      field_has_digit <= 1'b0;
      discarding      <= 1'b0;
      in_line         <= 1'b0;
      line_timer      <= '0;
      frame_vld       <= 1'b0;
    end else begin
      field_index     <= field_index_next;
      value_acc       <= value_acc_next;
      digits_seen     <= digits_seen_next;
      field_has_digit <= field_has_digit_next;
      discarding      <= discarding_next;
      in_line         <= in_line_next;
      line_timer      <= line_timer_next;
      if (rej || emit)      frame_vld <= 1'b1;
      else if (frame.ready) frame_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) stored_fields[field_index] <= value_acc;
  end

  always_ff @(posedge clk) begin
    if (rej || emit) begin
      frame_status <= rej;
      frame_unit   <= emit & ~all_deg;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        pos[i] <= emit ? vals[i][POS_W-1:0] : '0;
      end
    end
  end

  assign frame.valid         = frame_vld;
  assign frame.status        = frame_status;
  assign frame.unit_is_micro = frame_unit;
  assign frame.pos_0         = pos[0];
  assign frame.pos_1         = pos[1];
  assign frame.pos_2         = pos[2];
  assign frame.pos_3         = pos[3];
  assign frame.pos_4         = pos[4];
  assign frame.pos_5         = pos[5];

  a_discard_idle: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !in_line && field_index == '0)
    else $error("discarding while a line is open");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_line |-> line_timer == '0 && !field_has_digit && value_acc == '0)
    else $error("line state not cleared while idle");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    digits_seen <= DIG_MAX && field_index <= LAST_IDX)
    else $error("digit or field count out of bounds");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    frame_vld && frame_status |-> !frame_unit && pos[0] == '0 && pos[FIELD_COUNT-1] == '0)
    else $error("rejected frame carries data");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    frame_vld && !frame.ready |-> !pop)
    else $error("token consumed while result register is stalled");

endmodule

/* rtl/csv_servo_frame_parser_core.sv */
// Top level of the CSV servo frame parser: APB register file plus the
// classifier, token queue and parser. Depends on csvp_pkg, csvp_if and submodules.
//
// Each input item is either a received byte or one timer tick. The block takes one
// item per clock while the queue has room: the classifier writes a token into a two-entry
// queue in the cycle the item is accepted, and the parser consumes one token per clock
// unless stalled; the frame result is registered when the newline's (or failing byte's
// or tick's) token is consumed. The parser stalls only while its result register
// holds a frame that is not being taken; the queue then absorbs up to two items before
// item.ready drops. Registers (deg_min, deg_max, us_min, us_max, line_timeout_ticks)
// sit at byte addresses 0x0 to 0x10 and should be written only while the block is idle.
module csv_servo_frame_parser_core import csvp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  csvp_item_if.sink         item,
  csvp_frame_if.source      frame,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       q_full, q_empty, push, pop;
  tok_t       tok_in, tok_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deg_min <= RST_DEG_MIN;
      cfg.deg_max <= RST_DEG_MAX;
      cfg.us_min  <= RST_US_MIN;
      cfg.us_max  <= RST_US_MAX;
      cfg.timeout <= RST_TIMEOUT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEG_MIN: cfg.deg_min <= pwdata[POS_W-1:0];
        REG_DEG_MAX: cfg.deg_max <= pwdata[POS_W-1:0];
        REG_US_MIN:  cfg.us_min  <= pwdata[POS_W-1:0];
        REG_US_MAX:  cfg.us_max  <= pwdata[POS_W-1:0];
        REG_TIMEOUT: cfg.timeout <= pwdata[TMR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEG_MIN: prdata = {{(DATA_W-POS_W){1'b0}}, cfg.deg_min};
      REG_DEG_MAX: prdata = {{(DATA_W-POS_W){1'b0}}, cfg.deg_max};
      REG_US_MIN:  prdata = {{(DATA_W-POS_W){1'b0}}, cfg.us_min};
      REG_US_MAX:  prdata = {{(DATA_W-POS_W){1'b0}}, cfg.us_max};
      REG_TIMEOUT: prdata = {{(DATA_W-TMR_W){1'b0}}, cfg.timeout};
      default:     prdata = '0;
    endcase
  end

  csvp_front u_front (
    .item   (item),
    .q_full (q_full),
    .push   (push),
    .tok    (tok_in)
  );

  csvp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (tok_in),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (tok_out),
    .empty     (q_empty)
  );

  csvp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tok_valid (~q_empty),
    .tok       (tok_out),
    .pop       (pop),
    .frame     (frame)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for csv_servo_frame_parser_core: feeds byte/tick transactions,
// predicts every frame result and compares it with what the block emits.
// Depends on csvp_pkg, csvp_if and the RTL of the parser.
module testbench import csvp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_MAX        = 9;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } rx_item_t;

  typedef struct packed {
    logic                              status;
    logic                              micro;
    logic [FIELD_COUNT-1:0][POS_W-1:0] pos;
  } servo_frame_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  csvp_item_if  item_ch ();
  csvp_frame_if frame_ch ();

  csv_servo_frame_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch.sink),
    .frame   (frame_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  rx_item_t     tx_items[$];
  servo_frame_t exp_frames[$];
  int           queued_items = 0;
  int           mismatch_cnt = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           hold_left = 0;
  int           stall_cycles = 0;
  logic         hold_req = 1'b0;
  bit           src_idle = 1'b1;
  bit           sink_idle = 1'b1;

  // Limits as the block should hold them
  logic [POS_W-1:0] lim_deg_min, lim_deg_max, lim_us_min, lim_us_max;
  logic [TMR_W-1:0] lim_timeout;

  // Parser state mirror
  logic [2:0]       p_field;
  logic [ACC_W-1:0] p_acc;
  logic [2:0]       p_digits;
  logic             p_has_digit;
  logic [ACC_W-1:0] p_saved [FIELD_COUNT-1];
  logic             p_drop;
  logic             p_active;
  logic [TMR_W-1:0] p_ticks;

  function automatic void line_reset();
    p_field     = '0;
    p_acc       = '0;
    p_digits    = '0;
    p_has_digit = 1'b0;
    p_active    = 1'b0;
    p_ticks     = '0;
  endfunction

  function automatic servo_frame_t reject_frame(input logic then_drop);
    servo_frame_t f;
    f = '0;
    f.status = 1'b1;
    line_reset();
    p_drop = then_drop;
    return f;
  endfunction

  // Advances the mirror by one transaction; returns 1 when a frame result is due.
  function automatic bit parse_item(input rx_item_t it, output servo_frame_t fr);
    logic [ACC_W-1:0] vals [FIELD_COUNT];
    logic             all_deg;
    logic             all_us;
    fr = '0;
    if (it.cmd == CMD_TICK) begin
      if (!p_active || p_drop) return 1'b0;
      if (p_ticks != TMR_SAT) p_ticks++;
      if (p_ticks > lim_timeout) begin
        fr = reject_frame(1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    if (p_drop) begin
      if (it.ch == CH_LF) p_drop = 1'b0;
      return 1'b0;
    end
    if (!p_active) begin
      if (it.ch == CH_LF || it.ch == CH_CR) return 1'b0;
      p_active = 1'b1;
      p_ticks  = '0;
    end
    if (it.ch == CH_CR) return 1'b0;
    if (it.ch >= CH_0 && it.ch <= CH_9) begin
      if (p_digits >= MAX_DIGITS) begin
        fr = reject_frame(1'b1);
        return 1'b1;
      end
      p_acc = ACC_W'(int'(p_acc) * 10 + int'(it.ch - CH_0));
      p_digits++;
      p_has_digit = 1'b1;
      return 1'b0;
    end
    if (it.ch == CH_COMMA) begin
      if (!p_has_digit || p_field >= FIELD_COUNT - 1) begin
        fr = reject_frame(1'b1);
        return 1'b1;
      end
      p_saved[p_field] = p_acc;
      p_field++;
      p_acc       = '0;
      p_digits    = '0;
      p_has_digit = 1'b0;
      return 1'b0;
    end
    if (it.ch == CH_LF) begin
      // line over: no discarding after a bad newline
      if (!p_has_digit || p_field != FIELD_COUNT - 1) begin
        fr = reject_frame(1'b0);
        return 1'b1;
      end
      for (int i = 0; i < FIELD_COUNT - 1; i++) vals[i] = p_saved[i];
      vals[FIELD_COUNT-1] = p_acc;
      all_deg = 1'b1;
      all_us  = 1'b1;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        if (vals[i] < lim_deg_min || vals[i] > lim_deg_max) all_deg = 1'b0;
        if (vals[i] < lim_us_min || vals[i] > lim_us_max) all_us = 1'b0;
      end
      if (!all_deg && !all_us) begin
        fr = reject_frame(1'b0);
        return 1'b1;
      end
      fr.status = 1'b0;
      fr.micro  = !all_deg;  // degree mode wins when both fit
      for (int i = 0; i < FIELD_COUNT; i++) fr.pos[i] = vals[i][POS_W-1:0];
      line_reset();
      return 1'b1;
    end
    fr = reject_frame(1'b1);
    return 1'b1;
  endfunction

  function automatic string frame_text(input servo_frame_t f);
    string s;
    s = $sformatf("status=%0d micro=%0d pos=", f.status, f.micro);
    for (int i = 0; i < FIELD_COUNT; i++) s = $sformatf("%s%s%0d", s, (i == 0) ? "" : ",", f.pos[i]);
    return s;
  endfunction

  function automatic void flag_mismatch(input string detail);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, detail);
  endfunction

  // Source side: one transaction in flight, random gap after each while src_idle is set
  always @(posedge clk) begin : drive_items
    rx_item_t     got;
    rx_item_t     nxt;
    servo_frame_t fr;
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        got.cmd = item_ch.command;
        got.ch  = item_ch.rx_byte;
        if (parse_item(got, fr)) exp_frames.push_back(fr);
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap != 0) begin
          item_ch.valid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (tx_items.size() != 0) begin
          nxt = tx_items.pop_front();
          item_ch.valid   <= 1'b1;
          item_ch.command <= nxt.cmd;
          item_ch.rx_byte <= nxt.ch;
          send_gap        <= src_idle ? $urandom_range(0, GAP_MAX) : 0;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each frame against the oldest prediction
  always @(posedge clk) begin : watch_frames
    servo_frame_t got;
    servo_frame_t want;
    int           rgap;
    if (rst) begin
      frame_ch.ready <= 1'b0;
      recv_gap       <= 0;
    end else begin
      rgap = recv_gap;
      if (frame_ch.valid && frame_ch.ready) begin
        got.status = frame_ch.status;
        got.micro  = frame_ch.unit_is_micro;
        got.pos[0] = frame_ch.pos_0;
        got.pos[1] = frame_ch.pos_1;
        got.pos[2] = frame_ch.pos_2;
        got.pos[3] = frame_ch.pos_3;
        got.pos[4] = frame_ch.pos_4;
        got.pos[5] = frame_ch.pos_5;
        if (exp_frames.size() == 0) begin
          flag_mismatch({"frame with none expected: ", frame_text(got)});
        end else begin
          want = exp_frames.pop_front();
          if (got.status !== want.status || got.micro !== want.micro || got.pos !== want.pos)
            flag_mismatch({"expected ", frame_text(want), " got ", frame_text(got)});
        end
        rgap = sink_idle ? $urandom_range(0, GAP_MAX) : 0;
      end else if (rgap != 0) begin
        rgap--;
      end
      recv_gap       <= rgap;
      frame_ch.ready <= (rgap == 0) && (hold_left == 0);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin : sink_hold
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : watchdog
    if (rst || (item_ch.valid && item_ch.ready) || (frame_ch.valid && frame_ch.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] c);
    rx_item_t it;
    it.cmd = CMD_BYTE;
    it.ch  = c;
    tx_items.push_back(it);
    queued_items++;
  endtask

  task automatic push_tick();
    rx_item_t it;
    it.cmd = CMD_TICK;
    it.ch  = 8'($urandom_range(0, 255));  // don't-care payload
    tx_items.push_back(it);
    queued_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Wait until nothing is queued, in flight or predicted, plus pipeline slack
  task automatic drain();
    do @(posedge clk);
    while (tx_items.size() != 0 || item_ch.valid || exp_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEG_MIN: lim_deg_min = val[POS_W-1:0];
      REG_DEG_MAX: lim_deg_max = val[POS_W-1:0];
      REG_US_MIN:  lim_us_min  = val[POS_W-1:0];
      REG_US_MAX:  lim_us_max  = val[POS_W-1:0];
      REG_TIMEOUT: lim_timeout = val[TMR_W-1:0];
      default: ;
    endcase
  endtask

  // One line of random content; a broken line carries one flaw
  task automatic push_random_line(input bit well);
    logic [7:0] line[$];
    logic [7:0] bad;
    string      num;
    int         nf, v, lo, hi, flaw, burst;
    bit         micro;
    flaw = well ? -1 : $urandom_range(0, 6);
    nf = FIELD_COUNT;
    if (flaw == 0) nf = $urandom_range(1, FIELD_COUNT - 1);
    if (flaw == 1) nf = FIELD_COUNT + $urandom_range(1, 2);
    micro = $urandom_range(0, 1);
    lo = micro ? int'(lim_us_min) : int'(lim_deg_min);
    hi = micro ? int'(lim_us_max) : int'(lim_deg_max);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) line.push_back(CH_COMMA);
      if (lo <= hi && $urandom_range(0, 7) != 0) v = $urandom_range(lo, hi);
      else v = $urandom_range(0, 9999);
      num = $sformatf("%0d", v);
      repeat ($urandom_range(0, MAX_DIGITS - num.len())) line.push_back(CH_0);
      for (int i = 0; i < num.len(); i++) line.push_back(num[i]);
    end
    case (flaw)
      2: line.insert($urandom_range(0, 1) ? 0 : line.size(), CH_COMMA);
      3: begin
        line.push_front(CH_COMMA);
        repeat (MAX_DIGITS + 1) line.push_front(CH_0 + 8'($urandom_range(0, 9)));
      end
      4: begin
        do bad = 8'($urandom_range(0, 255));
        while ((bad >= CH_0 && bad <= CH_9) || bad == CH_COMMA || bad == CH_LF || bad == CH_CR);
        line.insert($urandom_range(0, line.size() - 1), bad);
      end
      6: line.push_back(CH_COMMA);
      default: ;
    endcase
    foreach (line[i]) begin
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 3)) push_tick();
      if ($urandom_range(0, 31) == 0) push_byte(CH_CR);
      push_byte(line[i]);
    end
    if (flaw == 5) begin
      // stalled line: run the timer past its limit where that is cheap
      burst = (lim_timeout < 200) ? int'(lim_timeout) + 1 : 200;
      repeat (burst) push_tick();
    end
    if ($urandom_range(0, 3) == 0) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  initial begin : stimulus
    int          target, sel;
    logic [11:0] dmin, dmax, umin, umax;
    logic [15:0] tmo;
    item_ch.valid   = 1'b0;
    item_ch.command = CMD_BYTE;
    item_ch.rx_byte = '0;
    frame_ch.ready  = 1'b0;
    lim_deg_min = RST_DEG_MIN;
    lim_deg_max = RST_DEG_MAX;
    lim_us_min  = RST_US_MIN;
    lim_us_max  = RST_US_MAX;
    lim_timeout = RST_TIMEOUT;
    line_reset();
    p_drop = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, limits at reset values
    push_text("\r\n\n");
    push_tick();
    push_text("90,5,175,12,0099,170\n");
    push_text("500,2400,1500,0600,999,2000\r\n");
    push_text("90,1500,90,90,90,90\n");
    push_text("4,90,90,90,90,90\n");
    push_text("1,2,3\n");
    push_text("1,,2\n");
    push_text("12345,1\n");
    push_text("1,2,3,4,5,6,7\n");
    push_text("1,2,3,4,5,\n");
    push_text("9x9\n");
    push_text("90");
    repeat (100) push_tick();
    push_text(",90,90,90,90,90\n");
    push_text("9");
    repeat (103) push_tick();
    push_text("5,5\n");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_text("\n");
    drain();

    // Full-scale overlapping ranges, zero timeout
    reg_write(REG_DEG_MIN, 32'd0);
    reg_write(REG_DEG_MAX, 32'd4095);
    reg_write(REG_US_MIN, 32'd0);
    reg_write(REG_US_MAX, 32'd4095);
    reg_write(REG_TIMEOUT, 32'd0);
    push_text("0,4095,0,4095,0,4095\n");
    push_text("4096,1,1,1,1,1\n");
    push_text("9999,1,1,1,1,9999\n");
    push_text("1");
    push_tick();
    push_text("\n");
    drain();

    // Single-point degree range, inverted microsecond range, timeout that never expires
    reg_write(REG_DEG_MIN, 32'd90);
    reg_write(REG_DEG_MAX, 32'd90);
    reg_write(REG_US_MIN, 32'd4095);
    reg_write(REG_US_MAX, 32'd0);
    reg_write(REG_TIMEOUT, 32'hFFFF);
    src_idle = 1'b0;
    push_text("90,90,90");
    repeat (300) push_tick();
    push_text(",90,90,90\n");
    push_text("4095,4095,4095,4095,4095,4095\n");
    push_text("91,90,90,90,90,90\n");
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          dmin = 12'($urandom_range(0, 20));
          dmax = 12'($urandom_range(150, 200));
          umin = 12'($urandom_range(400, 600));
          umax = 12'($urandom_range(2000, 2600));
        end
        1: begin
          dmin = 12'($urandom_range(0, 4095));
          dmax = 12'($urandom_range(0, 4095));
          umin = 12'($urandom_range(0, 4095));
          umax = 12'($urandom_range(0, 4095));
        end
        2: begin
          dmin = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
          dmax = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
          umin = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
          umax = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
        end
        default: begin
          dmin = 12'd0;
          dmax = 12'($urandom_range(100, 3000));
          umin = 12'($urandom_range(0, dmax));
          umax = 12'd4095;
        end
      endcase
      case ($urandom_range(0, 4))
        0: tmo = 16'd0;
        1: tmo = 16'($urandom_range(1, 30));
        2: tmo = 16'd100;
        3: tmo = 16'hFFFF;
        default: tmo = 16'($urandom_range(0, 65535));
      endcase
      // upper bits are junk the block must ignore
      reg_write(REG_DEG_MIN, ($urandom() & ~32'hFFF) | DATA_W'(dmin));
      reg_write(REG_DEG_MAX, ($urandom() & ~32'hFFF) | DATA_W'(dmax));
      reg_write(REG_US_MIN, ($urandom() & ~32'hFFF) | DATA_W'(umin));
      reg_write(REG_US_MAX, ($urandom() & ~32'hFFF) | DATA_W'(umax));
      reg_write(REG_TIMEOUT, ($urandom() & ~32'hFFFF) | DATA_W'(tmo));
      src_idle  = (ph % 3 != 1);
      sink_idle = (ph % 4 != 3);
      target = queued_items + RANDOM_ITEMS / RANDOM_PHASES;
      while (queued_items < target) begin
        sel = $urandom_range(0, 19);
        if (sel < 15) begin
          push_random_line(1'b1);
        end else if (sel < 18) begin
          push_random_line(1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0) push_tick();
            else push_byte(8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 1) != 0) push_byte(CH_LF);
        end
      end
      if (ph == 2) begin
        // receiver stalls while the sender keeps offering lines
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      drain();
    end

    if (mismatch_cnt == 0 && exp_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
